// File: rtl/core/rtri_pkg.sv
// Shared types and constants for the 2D range trilateration block.
`default_nettype none

package rtri_pkg;

    // Divider geometry: remainder, left-aligned low numerator bits, step count
    localparam int DivRemW  = 40;
    localparam int DivLowW  = 41;
    localparam int DivStepW = 6;

    // Square root geometry
    localparam int SqrtInW  = 64;
    localparam int SqrtOutW = 32;

    // Correction magnitude cap, 2^40
    localparam logic [DivLowW-1:0] CORR_CAP = 41'h100_0000_0000;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SHORT    = 2'd1;
    localparam logic [1:0] STATUS_SINGULAR = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_ANCHOR_A_X  = 3'd0;
    localparam logic [2:0] CFG_ANCHOR_A_Y  = 3'd1;
    localparam logic [2:0] CFG_ANCHOR_B_X  = 3'd2;
    localparam logic [2:0] CFG_ANCHOR_B_Y  = 3'd3;
    localparam logic [2:0] CFG_ANCHOR_C_X  = 3'd4;
    localparam logic [2:0] CFG_ANCHOR_C_Y  = 3'd5;
    localparam logic [2:0] CFG_HEIGHT_OFFS = 3'd6;

    typedef struct packed {
        logic                start;
        logic [DivStepW-1:0] steps;
        logic [DivRemW-1:0]  rem_init;
        logic [DivLowW-1:0]  num_low;
        logic [DivRemW-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic               ovf;
        logic [DivLowW-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic               start;
        logic [SqrtInW-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic                done;
        logic [SqrtOutW-1:0] root;
    } sqrt_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/rtri_sqrt.sv
// Bit-pair iterative integer square root (floor), one result bit per cycle.
`default_nettype none

module rtri_sqrt
    import rtri_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire sqrt_req_t req,
    output sqrt_rsp_t      rsp
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [SqrtInW-1:0] v_reg;
    logic [SqrtInW-1:0] res_reg;
    logic [SqrtInW-1:0] bit_reg;
    logic [SqrtInW-1:0] trial;
    logic               ge;

    // trial subtrahend for this step
    always_comb
    begin
        trial = res_reg + bit_reg;
        ge    = (v_reg >= trial);
    end

    // control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg && bit_reg[0])
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            v_reg   <= req.radicand;
            res_reg <= '0;
            bit_reg <= {2'b01, {(SqrtInW-2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = res_reg[SqrtOutW-1:0];

endmodule

`default_nettype wire

// File: rtl/core/rtri_div.sv
// Restoring bit-serial unsigned divider with a start-up overflow check.
`default_nettype none

module rtri_div
    import rtri_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DivStepW-1:0] cnt_reg, cnt_next;
    logic [DivRemW-1:0]  rem_reg;
    logic [DivLowW-1:0]  low_reg;
    logic [DivRemW-1:0]  den_reg;
    logic [DivLowW-1:0]  quot_reg;
    logic                ovf_reg;
    logic [DivRemW:0]    trial;
    logic [DivRemW:0]    diff;
    logic                fits;

    // one quotient bit per step
    always_comb
    begin
        trial = {rem_reg, low_reg[DivLowW-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    // control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DivStepW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath; remainder at start must be below the divisor or the quotient overflows
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.rem_init;
            low_reg  <= req.num_low;
            den_reg  <= req.den;
            quot_reg <= '0;
            ovf_reg  <= (req.rem_init >= req.den);
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[DivRemW-1:0] : trial[DivRemW-1:0];
            low_reg  <= low_reg << 1;
            quot_reg <= {quot_reg[DivLowW-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign rsp.quot = quot_reg;

endmodule

`default_nettype wire

// File: rtl/core/range_trilateration_2d.sv
// Items are taken one at a time; the rate is set by the bit-serial square root and divider
// (one division per Jacobian entry and per correction), which share one sequencer.
// A finished result waits in the output register while the next item is taken.
// Reset: estimate to the origin, anchors and height offset to their defaults, no result held.
`default_nettype none

module range_trilateration_2d
    import rtri_pkg::*;
#(
    parameter int ITERATIONS = 5
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [30:0] range_a,
    input  wire logic [30:0] range_b,
    input  wire logic [30:0] range_c,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic [1:0]       status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int ItW = $clog2(ITERATIONS + 1);

    // sequencer states
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_H2   = 5'd1;
    localparam logic [4:0] ST_H2W  = 5'd2;
    localparam logic [4:0] ST_R2   = 5'd3;
    localparam logic [4:0] ST_RCHK = 5'd4;
    localparam logic [4:0] ST_RSQ  = 5'd5;
    localparam logic [4:0] ST_DX   = 5'd6;
    localparam logic [4:0] ST_DXSQ = 5'd7;
    localparam logic [4:0] ST_DYSQ = 5'd8;
    localparam logic [4:0] ST_ZSQ  = 5'd9;
    localparam logic [4:0] ST_ZW   = 5'd10;
    localparam logic [4:0] ST_HXW  = 5'd11;
    localparam logic [4:0] ST_HYW  = 5'd12;
    localparam logic [4:0] ST_SUM  = 5'd13;
    localparam logic [4:0] ST_ACC  = 5'd14;
    localparam logic [4:0] ST_DET0 = 5'd15;
    localparam logic [4:0] ST_DET1 = 5'd16;
    localparam logic [4:0] ST_DET2 = 5'd17;
    localparam logic [4:0] ST_NX0  = 5'd18;
    localparam logic [4:0] ST_NX1  = 5'd19;
    localparam logic [4:0] ST_NX2  = 5'd20;
    localparam logic [4:0] ST_NY1  = 5'd21;
    localparam logic [4:0] ST_NY2  = 5'd22;
    localparam logic [4:0] ST_CXW  = 5'd23;
    localparam logic [4:0] ST_CYW  = 5'd24;
    localparam logic [4:0] ST_OUT  = 5'd25;

    // normal-equation sums, in order
    localparam logic [2:0] SUM_XX = 3'd0;
    localparam logic [2:0] SUM_XY = 3'd1;
    localparam logic [2:0] SUM_YY = 3'd2;
    localparam logic [2:0] SUM_GX = 3'd3;
    localparam logic [2:0] SUM_GY = 3'd4;

    localparam logic [1:0] IDX_A = 2'd0;
    localparam logic [1:0] IDX_B = 2'd1;
    localparam logic [1:0] IDX_C = 2'd2;

    // control state
    logic [4:0]     state_reg, state_next;
    logic [1:0]     idx_reg, idx_next;
    logic [2:0]     k_reg, k_next;
    logic [ItW-1:0] it_reg, it_next;
    logic [1:0]     status_reg, status_next;
    logic           out_valid_reg, out_valid_next;
    logic signed [31:0] est_x_reg, est_x_next;
    logic signed [31:0] est_y_reg, est_y_next;

    // configuration
    logic signed [31:0] anc_x_reg [3];
    logic signed [31:0] anc_y_reg [3];
    logic signed [31:0] height_reg;

    // working values
    logic [30:0]        r_reg [3];
    logic [63:0]        h2_reg;
    logic [31:0]        d_reg [3];
    logic signed [31:0] x_reg, y_reg;
    logic signed [31:0] dx_reg, dy_reg;
    logic [63:0]        sq_reg;
    logic [31:0]        z_reg;
    logic signed [17:0] hx_reg [3];
    logic signed [17:0] hy_reg [3];
    logic signed [33:0] dz_reg [3];
    logic signed [51:0] acc_reg;
    logic signed [18:0] a_reg, b_reg, c_reg;
    logic signed [35:0] gx_reg, gy_reg;
    logic signed [55:0] t_reg;
    logic signed [39:0] det_reg;
    logic signed [55:0] nx_reg, ny_reg;
    logic signed [71:0] prod_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic [1:0]         status_out_reg;

    // shared units
    logic signed [35:0] mul_a, mul_b;
    logic signed [71:0] mul_full;
    sqrt_req_t          sq_req;
    sqrt_rsp_t          sq_rsp;
    div_req_t           dv_req;
    div_rsp_t           dv_rsp;

    // combinational helpers
    logic               in_accept;
    logic               out_free;
    logic               last_iter;
    logic signed [31:0] anc_x_sel, anc_y_sel;
    logic [31:0]        dx_mag, dy_mag;
    logic [55:0]        nx_mag, ny_mag;
    logic [39:0]        det_mag;
    logic signed [51:0] acc_sum;
    logic signed [51:0] acc_shr;
    logic signed [39:0] det_calc;
    logic signed [55:0] diff_calc;
    logic signed [17:0] jac_new;
    logic signed [33:0] dz_new;
    logic signed [31:0] x_step, y_step;

    // x - anchor, saturated to +-(2^31 - 1)
    function automatic logic signed [31:0] clamp_diff(input logic signed [31:0] p,
                                                      input logic signed [31:0] q);
        logic signed [32:0] d;
        logic signed [31:0] res;
        d = 33'(p) - 33'(q);
        if (d > 33'sd2147483647)
            res = 32'sd2147483647;
        else if (d < -33'sd2147483647)
            res = -32'sd2147483647;
        else
            res = d[31:0];
        return res;
    endfunction

    // pos - signed correction, correction capped at 2^40, result saturated to 32 bits
    function automatic logic signed [31:0] step_pos(input logic signed [31:0] pos,
                                                    input logic [DivLowW-1:0] quot,
                                                    input logic ovf,
                                                    input logic neg);
        logic [DivLowW-1:0] mag;
        logic signed [42:0] wide;
        logic signed [31:0] res;
        mag  = (ovf || (quot > CORR_CAP)) ? CORR_CAP : quot;
        wide = neg ? (43'(pos) + $signed({2'b00, mag}))
                   : (43'(pos) - $signed({2'b00, mag}));
        if (wide > 43'sd2147483647)
            res = 32'sh7FFF_FFFF;
        else if (wide < -43'sd2147483648)
            res = 32'sh8000_0000;
        else
            res = wide[31:0];
        return res;
    endfunction

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_iter = (it_reg == ItW'(ITERATIONS - 1));
    assign cfg_ready = 1'b1;

    // anchor of the current index
    always_comb
    begin
        unique case (idx_reg)
            IDX_A:
            begin
                anc_x_sel = anc_x_reg[0];
                anc_y_sel = anc_y_reg[0];
            end
            IDX_B:
            begin
                anc_x_sel = anc_x_reg[1];
                anc_y_sel = anc_y_reg[1];
            end
            IDX_C:
            begin
                anc_x_sel = anc_x_reg[2];
                anc_y_sel = anc_y_reg[2];
            end
            default:
            begin
                anc_x_sel = anc_x_reg[0];
                anc_y_sel = anc_y_reg[0];
            end
        endcase
    end

    // magnitudes and derived values
    always_comb
    begin
        dx_mag    = dx_reg[31] ? 32'(-dx_reg) : 32'(dx_reg);
        dy_mag    = dy_reg[31] ? 32'(-dy_reg) : 32'(dy_reg);
        nx_mag    = nx_reg[55] ? 56'(-nx_reg) : 56'(nx_reg);
        ny_mag    = ny_reg[55] ? 56'(-ny_reg) : 56'(ny_reg);
        det_mag   = det_reg[39] ? 40'(-det_reg) : 40'(det_reg);
        acc_sum   = acc_reg + prod_reg[51:0];
        acc_shr   = acc_sum >>> 16;
        det_calc  = t_reg[39:0] - prod_reg[39:0];
        diff_calc = t_reg - prod_reg[55:0];
        jac_new   = {1'b0, dv_rsp.quot[16:0]};
        if ((state_reg == ST_HXW) ? dx_reg[31] : dy_reg[31])
            jac_new = -jac_new;
        dz_new    = $signed({2'b00, z_reg}) - $signed({2'b00, d_reg[idx_reg]});
        x_step    = step_pos(x_reg, dv_rsp.quot, dv_rsp.ovf, nx_reg[55] ^ det_reg[39]);
        y_step    = step_pos(y_reg, dv_rsp.quot, dv_rsp.ovf, ny_reg[55] ^ det_reg[39]);
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_H2:
            begin
                mul_a = 36'(height_reg);
                mul_b = 36'(height_reg);
            end
            ST_R2:
            begin
                mul_a = {5'b0, r_reg[idx_reg]};
                mul_b = {5'b0, r_reg[idx_reg]};
            end
            ST_DXSQ:
            begin
                mul_a = 36'(dx_reg);
                mul_b = 36'(dx_reg);
            end
            ST_DYSQ:
            begin
                mul_a = 36'(dy_reg);
                mul_b = 36'(dy_reg);
            end
            ST_SUM:
            begin
                unique case (k_reg)
                    SUM_XX:
                    begin
                        mul_a = 36'(hx_reg[idx_reg]);
                        mul_b = 36'(hx_reg[idx_reg]);
                    end
                    SUM_XY:
                    begin
                        mul_a = 36'(hx_reg[idx_reg]);
                        mul_b = 36'(hy_reg[idx_reg]);
                    end
                    SUM_YY:
                    begin
                        mul_a = 36'(hy_reg[idx_reg]);
                        mul_b = 36'(hy_reg[idx_reg]);
                    end
                    SUM_GX:
                    begin
                        mul_a = 36'(hx_reg[idx_reg]);
                        mul_b = 36'(dz_reg[idx_reg]);
                    end
                    SUM_GY:
                    begin
                        mul_a = 36'(hy_reg[idx_reg]);
                        mul_b = 36'(dz_reg[idx_reg]);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            ST_DET0:
            begin
                mul_a = 36'(a_reg);
                mul_b = 36'(c_reg);
            end
            ST_DET1:
            begin
                mul_a = 36'(b_reg);
                mul_b = 36'(b_reg);
            end
            ST_NX0:
            begin
                mul_a = 36'(c_reg);
                mul_b = gx_reg;
            end
            ST_NX1:
            begin
                mul_a = 36'(b_reg);
                mul_b = gy_reg;
            end
            ST_NX2:
            begin
                mul_a = 36'(a_reg);
                mul_b = gy_reg;
            end
            ST_NY1:
            begin
                mul_a = 36'(b_reg);
                mul_b = gx_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // sequencer and unit requests
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        it_next        = it_reg;
        status_next    = status_reg;
        est_x_next     = est_x_reg;
        est_y_next     = est_y_reg;
        out_valid_next = out_valid_reg && out_stall;
        sq_req         = '0;
        dv_req         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next  = ST_H2;
                    idx_next    = IDX_A;
                    it_next     = '0;
                    status_next = STATUS_OK;
                end
            end
            ST_H2:   state_next = ST_H2W;
            ST_H2W:  state_next = ST_R2;
            ST_R2:   state_next = ST_RCHK;
            ST_RCHK:
            begin
                if (prod_reg[63:0] < h2_reg)
                begin
                    status_next = STATUS_SHORT;
                    state_next  = ST_OUT;
                end
                else
                begin
                    sq_req.start    = 1'b1;
                    sq_req.radicand = prod_reg[63:0] - h2_reg;
                    state_next      = ST_RSQ;
                end
            end
            ST_RSQ:
            begin
                if (sq_rsp.done)
                begin
                    if (idx_reg == IDX_C)
                    begin
                        idx_next   = IDX_A;
                        state_next = ST_DX;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_R2;
                    end
                end
            end
            ST_DX:   state_next = ST_DXSQ;
            ST_DXSQ: state_next = ST_DYSQ;
            ST_DYSQ: state_next = ST_ZSQ;
            ST_ZSQ:
            begin
                sq_req.start    = 1'b1;
                sq_req.radicand = sq_reg + prod_reg[63:0];
                state_next      = ST_ZW;
            end
            ST_ZW:
            begin
                if (sq_rsp.done)
                begin
                    if (sq_rsp.root == '0)
                    begin
                        status_next = STATUS_SINGULAR;
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        // |dx| * 2^16 / z, quotient below 2^17
                        dv_req.start    = 1'b1;
                        dv_req.steps    = DivStepW'(17);
                        dv_req.rem_init = {10'b0, dx_mag[30:1]};
                        dv_req.num_low  = {dx_mag[0], 40'b0};
                        dv_req.den      = {8'b0, sq_rsp.root};
                        state_next      = ST_HXW;
                    end
                end
            end
            ST_HXW:
            begin
                if (dv_rsp.done)
                begin
                    dv_req.start    = 1'b1;
                    dv_req.steps    = DivStepW'(17);
                    dv_req.rem_init = {10'b0, dy_mag[30:1]};
                    dv_req.num_low  = {dy_mag[0], 40'b0};
                    dv_req.den      = {8'b0, z_reg};
                    state_next      = ST_HYW;
                end
            end
            ST_HYW:
            begin
                if (dv_rsp.done)
                begin
                    if (idx_reg == IDX_C)
                    begin
                        idx_next   = IDX_A;
                        k_next     = SUM_XX;
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_DX;
                    end
                end
            end
            ST_SUM:  state_next = ST_ACC;
            ST_ACC:
            begin
                state_next = ST_SUM;
                if (idx_reg == IDX_C)
                begin
                    idx_next = IDX_A;
                    if (k_reg == SUM_GY)
                        state_next = ST_DET0;
                    else
                        k_next = k_reg + 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DET0: state_next = ST_DET1;
            ST_DET1: state_next = ST_DET2;
            ST_DET2:
            begin
                if (det_calc == '0)
                begin
                    status_next = STATUS_SINGULAR;
                    state_next  = ST_OUT;
                end
                else
                begin
                    state_next = ST_NX0;
                end
            end
            ST_NX0:  state_next = ST_NX1;
            ST_NX1:  state_next = ST_NX2;
            ST_NX2:  state_next = ST_NY1;
            ST_NY1:  state_next = ST_NY2;
            ST_NY2:
            begin
                // |nx| * 2^16 / |det|; quotient of 2^41 or more shows as overflow
                dv_req.start    = 1'b1;
                dv_req.steps    = DivStepW'(41);
                dv_req.rem_init = {9'b0, nx_mag[55:25]};
                dv_req.num_low  = {nx_mag[24:0], 16'b0};
                dv_req.den      = det_mag;
                state_next      = ST_CXW;
            end
            ST_CXW:
            begin
                if (dv_rsp.done)
                begin
                    dv_req.start    = 1'b1;
                    dv_req.steps    = DivStepW'(41);
                    dv_req.rem_init = {9'b0, ny_mag[55:25]};
                    dv_req.num_low  = {ny_mag[24:0], 16'b0};
                    dv_req.den      = det_mag;
                    state_next      = ST_CYW;
                end
            end
            ST_CYW:
            begin
                if (dv_rsp.done)
                begin
                    if (last_iter)
                    begin
                        est_x_next = x_reg;
                        est_y_next = y_step;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        it_next    = it_reg + 1'b1;
                        idx_next   = IDX_A;
                        state_next = ST_DX;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers, estimate and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= IDX_A;
            k_reg         <= SUM_XX;
            it_reg        <= '0;
            status_reg    <= STATUS_OK;
            out_valid_reg <= 1'b0;
            est_x_reg     <= '0;
            est_y_reg     <= '0;
            anc_x_reg[0]  <= 32'sd117965;
            anc_y_reg[0]  <= -32'sd101581;
            anc_x_reg[1]  <= -32'sd117965;
            anc_y_reg[1]  <= '0;
            anc_x_reg[2]  <= 32'sd117965;
            anc_y_reg[2]  <= 32'sd101581;
            height_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            k_reg         <= k_next;
            it_reg        <= it_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
            est_x_reg     <= est_x_next;
            est_y_reg     <= est_y_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_ANCHOR_A_X:  anc_x_reg[0] <= cfg_data;
                    CFG_ANCHOR_A_Y:  anc_y_reg[0] <= cfg_data;
                    CFG_ANCHOR_B_X:  anc_x_reg[1] <= cfg_data;
                    CFG_ANCHOR_B_Y:  anc_y_reg[1] <= cfg_data;
                    CFG_ANCHOR_C_X:  anc_x_reg[2] <= cfg_data;
                    CFG_ANCHOR_C_Y:  anc_y_reg[2] <= cfg_data;
                    CFG_HEIGHT_OFFS: height_reg   <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    // working datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    r_reg[0] <= range_a;
                    r_reg[1] <= range_b;
                    r_reg[2] <= range_c;
                    x_reg    <= est_x_reg;
                    y_reg    <= est_y_reg;
                end
            end
            ST_H2W:  h2_reg <= prod_reg[63:0];
            ST_RSQ:
            begin
                if (sq_rsp.done)
                    d_reg[idx_reg] <= sq_rsp.root;
            end
            ST_DX:
            begin
                dx_reg <= clamp_diff(x_reg, anc_x_sel);
                dy_reg <= clamp_diff(y_reg, anc_y_sel);
            end
            ST_DYSQ: sq_reg <= prod_reg[63:0];
            ST_ZW:
            begin
                if (sq_rsp.done)
                    z_reg <= sq_rsp.root;
            end
            ST_HXW:
            begin
                if (dv_rsp.done)
                    hx_reg[idx_reg] <= jac_new;
            end
            ST_HYW:
            begin
                acc_reg <= '0;
                if (dv_rsp.done)
                begin
                    hy_reg[idx_reg] <= jac_new;
                    dz_reg[idx_reg] <= dz_new;
                end
            end
            ST_ACC:
            begin
                if (idx_reg == IDX_C)
                begin
                    acc_reg <= '0;
                    unique case (k_reg)
                        SUM_XX:  a_reg  <= acc_shr[18:0];
                        SUM_XY:  b_reg  <= acc_shr[18:0];
                        SUM_YY:  c_reg  <= acc_shr[18:0];
                        SUM_GX:  gx_reg <= acc_shr[35:0];
                        SUM_GY:  gy_reg <= acc_shr[35:0];
                        default: ;
                    endcase
                end
                else
                begin
                    acc_reg <= acc_sum;
                end
            end
            ST_DET1: t_reg   <= prod_reg[55:0];
            ST_DET2: det_reg <= det_calc;
            ST_NX1:  t_reg   <= prod_reg[55:0];
            ST_NX2:  nx_reg  <= diff_calc;
            ST_NY1:  t_reg   <= prod_reg[55:0];
            ST_NY2:  ny_reg  <= diff_calc;
            ST_CXW:
            begin
                if (dv_rsp.done)
                    x_reg <= x_step;
            end
            ST_CYW:
            begin
                if (dv_rsp.done)
                    y_reg <= y_step;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    pos_x_reg      <= est_x_reg;
                    pos_y_reg      <= est_y_reg;
                    status_out_reg <= status_reg;
                end
            end
            default: ;
        endcase
    end

    rtri_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

    rtri_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dv_req),
        .rsp   (dv_rsp)
    );

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign status    = status_out_reg;

endmodule

`default_nettype wire
